FILE: hw/rtl/rpca_pkg.sv
`default_nettype none
package rpca_pkg;

  typedef logic [7:0] chan_t;
  // Index 0 red, 1 green, 2 blue
  typedef chan_t [2:0] pix_t;

  typedef enum logic [1:0] {
    FX_NONE  = 2'd0,
    FX_GRAY  = 2'd1,
    FX_SEPIA = 2'd2,
    FX_NEG   = 2'd3
  } effect_t;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_CONTRAST   = 3'd1;
  localparam logic [2:0] REG_SATURATION = 3'd2;
  localparam logic [2:0] REG_SAT_EN     = 3'd3;
  localparam logic [2:0] REG_EFFECT     = 3'd4;

  localparam int NSTG = 6;

  // Q16 luma weights
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  // Q16 sepia matrix, row = output channel
  localparam logic [15:0] SEPIA_COEF [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  // Q16 luma, below 2^24 for 8-bit channels
  function automatic logic [23:0] luma(pix_t p);
    return 24'(p[0]) * 24'(LUMA_R) + 24'(p[1]) * 24'(LUMA_G) + 24'(p[2]) * 24'(LUMA_B);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rpca_bc.sv
`default_nettype none
// Brightness/contrast, one register stage, three channel lanes.
module rpca_bc (
  input  logic          clk,
  input  logic          en,
  input  logic [7:0]    brightness,
  input  logic [7:0]    contrast,
  input  rpca_pkg::pix_t pix_i,
  output rpca_pkg::pix_t pix_o
);
  import rpca_pkg::*;

  logic signed [9:0]  bd;
  logic signed [18:0] off;
  pix_t               pix_nxt;
  pix_t               pix_r;

  always_comb begin
    logic signed [9:0]  dp;
    logic signed [18:0] n;
    bd  = $signed({2'b00, brightness}) - 10'sd128;
    off = 19'(bd) * 19'sd510;
    for (int i = 0; i < 3; i++) begin
      dp = $signed({1'b0, pix_i[i], 1'b0}) - 10'sd255;
      n  = 19'(dp) * $signed({11'b0, contrast}) + 19'sd32640 + off;
      if (n <= 19'sd0) begin
        pix_nxt[i] = 8'd0;
      end else if (|n[17:16]) begin
        pix_nxt[i] = 8'd255;
      end else begin
        pix_nxt[i] = n[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_o = pix_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rpca_sat.sv
`default_nettype none
// Saturation: luma, then gain product, then clamp. Three stages.
module rpca_sat (
  input  logic          clk,
  input  logic [2:0]    en,
  input  logic [7:0]    saturation,
  input  logic          sat_en,
  input  rpca_pkg::pix_t pix_i,
  output rpca_pkg::pix_t pix_o
);
  import rpca_pkg::*;

  // stage a: luma
  pix_t               a_pix_r;
  logic [23:0]        a_luma_r;
  // stage b: gain products
  pix_t               b_pix_r;
  logic [23:0]        b_luma_r;
  logic signed [33:0] b_prod_r [3];
  logic signed [33:0] b_prod_nxt [3];
  // stage c: clamped result
  pix_t               c_pix_r;
  pix_t               c_pix_nxt;

  always_comb begin
    logic signed [25:0] d;
    for (int i = 0; i < 3; i++) begin
      d = $signed({2'b00, a_pix_r[i], 16'h0000}) - $signed({2'b00, a_luma_r});
      b_prod_nxt[i] = 34'(d) * $signed({26'b0, saturation});
    end
  end

  always_comb begin
    logic signed [34:0] t;
    for (int i = 0; i < 3; i++) begin
      t = $signed({4'b0000, b_luma_r, 7'b0000000}) + 35'(b_prod_r[i]);
      if (!sat_en) begin
        c_pix_nxt[i] = b_pix_r[i];
      end else if (t <= 35'sd0) begin
        c_pix_nxt[i] = 8'd0;
      end else if (|t[33:31]) begin
        c_pix_nxt[i] = 8'd255;
      end else begin
        c_pix_nxt[i] = t[30:23];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_pix_r  <= pix_i;
      a_luma_r <= luma(pix_i);
    end
    if (en[1]) begin
      b_pix_r  <= a_pix_r;
      b_luma_r <= a_luma_r;
      for (int i = 0; i < 3; i++) begin
        b_prod_r[i] <= b_prod_nxt[i];
      end
    end
    if (en[2]) begin
      c_pix_r <= c_pix_nxt;
    end
  end

  assign pix_o = c_pix_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rpca_fx.sv
`default_nettype none
// Effects: sums in the first stage, select and clamp into the output register.
module rpca_fx (
  input  logic             clk,
  input  logic [1:0]       en,
  input  rpca_pkg::effect_t mode,
  input  rpca_pkg::pix_t    pix_i,
  output rpca_pkg::pix_t    pix_o
);
  import rpca_pkg::*;

  pix_t        s_pix_r;
  logic [23:0] s_gray_r;
  logic [24:0] s_sep_r [3];
  logic [24:0] s_sep_nxt [3];
  pix_t        o_pix_r;
  pix_t        o_pix_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sep_nxt[i] = 25'(pix_i[0]) * 25'(SEPIA_COEF[i][0])
                   + 25'(pix_i[1]) * 25'(SEPIA_COEF[i][1])
                   + 25'(pix_i[2]) * 25'(SEPIA_COEF[i][2]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (mode)
        FX_GRAY:  o_pix_nxt[i] = s_gray_r[23:16];
        FX_SEPIA: o_pix_nxt[i] = s_sep_r[i][24] ? 8'd255 : s_sep_r[i][23:16];
        FX_NEG:   o_pix_nxt[i] = ~s_pix_r[i];
        default:  o_pix_nxt[i] = s_pix_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_pix_r  <= pix_i;
      s_gray_r <= luma(pix_i);
      for (int i = 0; i < 3; i++) begin
        s_sep_r[i] <= s_sep_nxt[i];
      end
    end
    if (en[1]) begin
      o_pix_r <= o_pix_nxt;
    end
  end

  assign pix_o = o_pix_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rgb_pixel_color_adjust_core.sv
// RGB888 color adjust: brightness/contrast, optional saturation, then an
// optional effect (grayscale, sepia, negative), all in integer fixed point.
//
// Input channel in_valid/in_ready carries one pixel word (in_red_in,
// in_green_in, in_blue_in); output channel out_valid/out_ready carries the
// adjusted pixel word. One result word per input word, in order.
//
// Six register stages, from the accepting register through to out_valid:
// one stage of brightness/contrast, three of saturation (luma, gain multiply,
// clamp), two of effect (coefficient sums, select into the output register).
// Throughput is one word per cycle while out_ready stays high; the 8x26
// saturation multiply stage sets the clock path.
//
// Each stage has its own valid bit and loads when it is empty or the stage
// after it moves, so a stalled receiver fills the bubbles first and only
// then drops in_ready. Nothing is lost or repeated while stalled.
//
// Synchronous reset empties the pipeline and loads the registers with
// brightness 128, contrast 128, saturation 128, saturation on, no effect.
// Write registers through cfg_we/cfg_index/cfg_data only while idle.
`default_nettype none
module rgb_pixel_color_adjust_core (
  input  logic       clk,
  input  logic       rst_n,
  // input word
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  // result word
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  // register writes
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rpca_pkg::*;

  // config registers
  logic [7:0] bright_r;
  logic [7:0] contrast_r;
  logic [7:0] sat_r;
  logic       sat_en_r;
  effect_t    effect_r;

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] ld;

  pix_t pix_in;
  pix_t pix_bc;
  pix_t pix_sat;
  pix_t pix_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r   <= 8'd128;
      contrast_r <= 8'd128;
      sat_r      <= 8'd128;
      sat_en_r   <= 1'b1;
      effect_r   <= FX_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS: bright_r   <= cfg_data;
        REG_CONTRAST:   contrast_r <= cfg_data;
        REG_SATURATION: sat_r      <= cfg_data;
        REG_SAT_EN:     sat_en_r   <= cfg_data[0];
        REG_EFFECT:     effect_r   <= effect_t'(cfg_data[1:0]);
        default:        ;  // unmapped index, ignored
      endcase
    end
  end

  // Stage k loads when empty or when stage k+1 loads; last stage frees on
  // out_ready. Ripples back from the output register.
  always_comb begin
    ld[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
    vld_nxt = vld_r;
    if (ld[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[NSTG-1];

  assign pix_in[0] = in_red_in;
  assign pix_in[1] = in_green_in;
  assign pix_in[2] = in_blue_in;

  rpca_bc u_bc (
    .clk        (clk),
    .en         (ld[0]),
    .brightness (bright_r),
    .contrast   (contrast_r),
    .pix_i      (pix_in),
    .pix_o      (pix_bc)
  );

  rpca_sat u_sat (
    .clk        (clk),
    .en         (ld[3:1]),
    .saturation (sat_r),
    .sat_en     (sat_en_r),
    .pix_i      (pix_bc),
    .pix_o      (pix_sat)
  );

  rpca_fx u_fx (
    .clk   (clk),
    .en    (ld[5:4]),
    .mode  (effect_r),
    .pix_i (pix_sat),
    .pix_o (pix_out)
  );

  assign out_red_out   = pix_out[0];
  assign out_green_out = pix_out[1];
  assign out_blue_out  = pix_out[2];

  // an empty or draining output slot always lets a word in
  a_ready_when_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output slot frees");

  // word count in flight tracks accepts on both sides
  a_word_count : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) == $past($countones(vld_r))
      + $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready))))
    else $error("pipeline lost or duplicated a word");

  // pipeline comes out of reset empty
  a_reset_empty : assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (vld_r == '0))
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
